@@ hw/rtl/ogw_pkg.sv @@
// ----------------------------------------------------------------------------
// ogw_pkg
// Shared types, constants and tables of the occupancy grid insert/warp block.
// ----------------------------------------------------------------------------
package ogw_pkg;

	// grid size defaults
	localparam int GridRowsDef = 128;
	localparam int GridColsDef = 128;

	// scale register reset: 20.0 pixels per metre in Q8.8
	localparam logic [15:0] PpmReset = 16'd5120;

	// operation codes
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_MOVE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// angle folding in Q2.13
	localparam logic signed [16:0] PiQ13     = 17'sd25736;
	localparam logic signed [16:0] HalfPiQ13 = 17'sd12868;

	// CORDIC constants in Q.16
	localparam int                 CordicSteps = 16;
	localparam logic signed [19:0] CordicGain  = 20'sd39797;

	// input item
	typedef struct packed {
		op_t                operation;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [23:0]        point_color;
		logic signed [15:0] turn_angle;
		logic signed [15:0] shift_x;
		logic signed [15:0] shift_y;
		logic [6:0]         read_row;
		logic [6:0]         read_col;
	} req_t;

	// result item
	typedef struct packed {
		logic [23:0] cell_color;
		logic        point_stored;
	} rsp_t;

	// sine/cosine unit status toward the sequencer
	typedef struct packed {
		logic               done;
		logic signed [15:0] sin_v;
		logic signed [15:0] cos_v;
	} cordic_res_t;

	// arctangent of 2^-k in Q.16
	function automatic logic [15:0] atan_q16(input logic [3:0] k);
		logic [15:0] r;
		case (k)
			4'd0:    r = 16'd51472;
			4'd1:    r = 16'd30386;
			4'd2:    r = 16'd16055;
			4'd3:    r = 16'd8150;
			4'd4:    r = 16'd4091;
			4'd5:    r = 16'd2047;
			4'd6:    r = 16'd1024;
			4'd7:    r = 16'd512;
			4'd8:    r = 16'd256;
			4'd9:    r = 16'd128;
			4'd10:   r = 16'd64;
			4'd11:   r = 16'd32;
			4'd12:   r = 16'd16;
			4'd13:   r = 16'd8;
			4'd14:   r = 16'd4;
			default: r = 16'd2;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/occupancy_grid_point_insert_and_warp.sv @@
// ----------------------------------------------------------------------------
// occupancy_grid_point_insert_and_warp
// Robot-centred colour grid: add point, rigid move, clear and cell read.
// ----------------------------------------------------------------------------
//  channel  | signals                       | direction
//  request  | req_valid, req_ready, req_data| in, valid/ready
//  response | rsp_valid, rsp_ready, rsp_data| out, valid/ready
//  config   | cfg_we, cfg_wdata             | in, write-only scale register
//
// A move runs the CORDIC, 6 products on the shared multiplier, then one
// cell per cycle through the grid RAM read port. After reset a clearing
// pass zeroes the grid; no item is taken meanwhile. A finished item waits
// in the output register while the next item is accepted; a stalled
// response holds the sequencer at its end.
// ----------------------------------------------------------------------------
module occupancy_grid_point_insert_and_warp #(
	parameter int GRID_ROWS = ogw_pkg::GridRowsDef,
	parameter int GRID_COLS = ogw_pkg::GridColsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ogw_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ogw_pkg::rsp_t  rsp_data,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata
);

	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int CX    = (GRID_ROWS + 1) / 2;
	localparam int CY    = (GRID_COLS + 1) / 2;
	localparam int PW    = 36;
	localparam logic signed [PW-1:0] CXQ     = PW'(longint'(CX) * 65536);
	localparam logic signed [PW-1:0] CYQ     = PW'(longint'(CY) * 65536);
	localparam logic signed [PW-1:0] ROW_LIM = PW'(longint'(GRID_ROWS - 1) * 65536);
	localparam logic signed [PW-1:0] COL_LIM = PW'(longint'(GRID_COLS - 1) * 65536);
	localparam logic signed [PW-1:0] HALF    = PW'(32768);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_INIT  = 12'b0000_0000_0010,
		ST_CLR   = 12'b0000_0000_0100,
		ST_RD    = 12'b0000_0000_1000,
		ST_RD2   = 12'b0000_0001_0000,
		ST_MUL   = 12'b0000_0010_0000,
		ST_PWR   = 12'b0000_0100_0000,
		ST_CORD  = 12'b0000_1000_0000,
		ST_BASE  = 12'b0001_0000_0000,
		ST_SWEEP = 12'b0010_0000_0000,
		ST_DRAIN = 12'b0100_0000_0000,
		ST_FIN   = 12'b1000_0000_0000
	} state_t;

	state_t               state_q;
	ogw_pkg::req_t        item_q;
	logic [15:0]          ppm_q;
	logic                 sel_q;
	logic [AW-1:0]        clr_q;
	logic [2:0]           m_q;
	logic signed [33:0]   prod_q [6];
	logic signed [PW-1:0] px_q, py_q, pxr_q, pyr_q;
	logic [RW-1:0]        i_q;
	logic [CW-1:0]        j_q;
	logic                 act_s1, in_s1;
	logic [AW-1:0]        dst_s1;
	logic [23:0]          color_q;
	logic                 stored_q;
	logic                 rsp_valid_q;
	ogw_pkg::rsp_t        rsp_q;

	ogw_pkg::cordic_res_t cres;
	logic                 cstart;

	logic signed [16:0]   mul_a, mul_b;
	logic signed [33:0]   mul_p;
	logic                 is_add;
	logic [2:0]           m_last;

	logic signed [PW-1:0] c4, s4, uval, vval, uu, vv;
	logic                 pt_in;
	logic signed [PW-1:0] rsum, qsum;
	logic                 src_in;
	logic [AW-1:0]        src_addr;

	logic                 live_we, scr_we;
	logic [AW-1:0]        live_waddr, live_raddr, scr_waddr;
	logic [23:0]          live_wdata, scr_wdata, live_rdata;
	logic                 a_we, b_we;
	logic [AW-1:0]        a_waddr, b_waddr;
	logic [23:0]          a_wdata, b_wdata, a_rdata, b_rdata;

	// sine/cosine unit
	assign cstart = (state_q == ST_IDLE) && req_valid && (req_data.operation == ogw_pkg::OP_MOVE);

	ogw_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart),
		.angle  (req_data.turn_angle),
		.res    (cres)
	);

	// shared multiplier operand select
	assign is_add = (item_q.operation == ogw_pkg::OP_ADD);
	assign m_last = is_add ? 3'd1 : 3'd5;
	always_comb begin
		case (m_q)
			3'd0: begin
				mul_a = $signed({1'b0, ppm_q});
				mul_b = is_add ? 17'(item_q.point_x) : 17'(item_q.shift_x);
			end
			3'd1: begin
				mul_a = $signed({1'b0, ppm_q});
				mul_b = is_add ? 17'(item_q.point_y) : 17'(item_q.shift_y);
			end
			3'd2: begin
				mul_a = $signed(17'(CX));
				mul_b = 17'(cres.cos_v);
			end
			3'd3: begin
				mul_a = $signed(17'(CY));
				mul_b = 17'(cres.sin_v);
			end
			3'd4: begin
				mul_a = $signed(17'(CX));
				mul_b = 17'(cres.sin_v);
			end
			default: begin
				mul_a = $signed(17'(CY));
				mul_b = 17'(cres.cos_v);
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// point cell from the registered products
	assign uval  = CXQ + HALF - PW'(prod_q[0]);
	assign vval  = CYQ + HALF - PW'(prod_q[1]);
	assign uu    = uval >>> 16;
	assign vv    = vval >>> 16;
	assign pt_in = !uu[PW-1] && (uu < PW'(GRID_ROWS)) && !vv[PW-1] && (vv < PW'(GRID_COLS));

	// per-cell source of the warp
	assign c4       = PW'(cres.cos_v) <<< 2;
	assign s4       = PW'(cres.sin_v) <<< 2;
	assign rsum     = px_q + HALF;
	assign qsum     = py_q + HALF;
	assign src_in   = (px_q > 0) && (px_q < ROW_LIM) && (py_q > 0) && (py_q < COL_LIM);
	assign src_addr = {rsum[16 +: RW], qsum[16 +: CW]};

	// live and scratch port requests
	always_comb begin
		live_we    = 1'b0;
		live_waddr = clr_q;
		live_wdata = '0;
		if (state_q == ST_INIT || state_q == ST_CLR) begin
			live_we = 1'b1;
		end else if (state_q == ST_PWR) begin
			live_we    = pt_in;
			live_waddr = {uu[RW-1:0], vv[CW-1:0]};
			live_wdata = item_q.point_color;
		end
		live_raddr = (state_q == ST_SWEEP) ? src_addr
			: {RW'(item_q.read_row), CW'(item_q.read_col)};
		scr_we    = act_s1;
		scr_waddr = dst_s1;
		scr_wdata = in_s1 ? live_rdata : '0;
	end

	// map roles onto the two buffers
	assign a_we       = sel_q ? scr_we : live_we;
	assign a_waddr    = sel_q ? scr_waddr : live_waddr;
	assign a_wdata    = sel_q ? scr_wdata : live_wdata;
	assign b_we       = sel_q ? live_we : scr_we;
	assign b_waddr    = sel_q ? live_waddr : scr_waddr;
	assign b_wdata    = sel_q ? live_wdata : scr_wdata;
	assign live_rdata = sel_q ? b_rdata : a_rdata;

	ogw_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (live_raddr),
		.rdata (a_rdata)
	);

	ogw_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (live_raddr),
		.rdata (b_rdata)
	);

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_q <= ogw_pkg::PpmReset;
		end else if (cfg_we) begin
			ppm_q <= cfg_wdata;
		end
	end

	// warp write stage, one cell behind the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= (state_q == ST_SWEEP);
		end
	end
	always_ff @(posedge clk) begin
		in_s1  <= src_in;
		dst_s1 <= {i_q, j_q};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sel_q       <= 1'b0;
			clr_q       <= '0;
			m_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// the final state reloads the output register itself
			if (rsp_valid_q && rsp_ready && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						item_q   <= req_data;
						color_q  <= '0;
						stored_q <= 1'b0;
						m_q      <= '0;
						clr_q    <= '0;
						case (req_data.operation)
							ogw_pkg::OP_ADD:   state_q <= ST_MUL;
							ogw_pkg::OP_MOVE:  state_q <= ST_CORD;
							ogw_pkg::OP_CLEAR: state_q <= ST_CLR;
							default:           state_q <= ST_RD;
						endcase
					end
				end
				ST_INIT, ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_FIN;
					end
				end
				ST_RD: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (32'(item_q.read_row) < GRID_ROWS && 32'(item_q.read_col) < GRID_COLS) begin
						color_q <= live_rdata;
					end
					state_q <= ST_FIN;
				end
				ST_CORD: begin
					if (cres.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q[m_q] <= mul_p;
					m_q         <= m_q + 3'd1;
					if (m_q == m_last) begin
						state_q <= is_add ? ST_PWR : ST_BASE;
					end
				end
				ST_PWR: begin
					stored_q <= pt_in;
					state_q  <= ST_FIN;
				end
				ST_BASE: begin
					pxr_q   <= CXQ - PW'(prod_q[0]) - ((PW'(prod_q[2]) - PW'(prod_q[3])) <<< 2);
					pyr_q   <= CYQ - PW'(prod_q[1]) - ((PW'(prod_q[4]) + PW'(prod_q[5])) <<< 2);
					px_q    <= CXQ - PW'(prod_q[0]) - ((PW'(prod_q[2]) - PW'(prod_q[3])) <<< 2);
					py_q    <= CYQ - PW'(prod_q[1]) - ((PW'(prod_q[4]) + PW'(prod_q[5])) <<< 2);
					i_q     <= '0;
					j_q     <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (32'(j_q) == GRID_COLS - 1) begin
						j_q   <= '0;
						i_q   <= i_q + 1'b1;
						pxr_q <= pxr_q + c4;
						pyr_q <= pyr_q + s4;
						px_q  <= pxr_q + c4;
						py_q  <= pyr_q + s4;
						if (32'(i_q) == GRID_ROWS - 1) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						j_q  <= j_q + 1'b1;
						px_q <= px_q - s4;
						py_q <= py_q + c4;
					end
				end
				ST_DRAIN: begin
					sel_q   <= !sel_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.cell_color   <= color_q;
						rsp_q.point_stored <= stored_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// buffer roles swap only at the end of a sweep
	a_sel_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_q != $past(sel_q)) |-> $past(state_q == ST_DRAIN))
		else $error("buffer select changed outside a move");

	// scratch writes come in the cycle after their sweep reads
	a_scr_trail: assert property (@(posedge clk) disable iff (!arst_n)
		scr_we |-> $past(state_q == ST_SWEEP))
		else $error("scratch write without a sweep read");

	// live buffer is read-only while it is warped
	a_live_ro: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP || state_q == ST_DRAIN) |-> !live_we)
		else $error("live buffer written during a sweep");

	// sin/cos finish only while the sequencer waits for them
	a_cord_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cres.done |-> (state_q == ST_CORD))
		else $error("CORDIC result outside its wait state");

endmodule

@@ hw/rtl/ogw_ram.sv @@
// ----------------------------------------------------------------------------
// ogw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ogw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/ogw_cordic.sv @@
// ----------------------------------------------------------------------------
// ogw_cordic
// Iterative rotation CORDIC: one micro-rotation per cycle, Q1.14 sin/cos.
// ----------------------------------------------------------------------------
module ogw_cordic (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [15:0]     angle,
	output ogw_pkg::cordic_res_t   res
);

	logic signed [19:0] x_q, y_q, z_q;
	logic [3:0]         k_q;
	logic               busy_q, fin_q, neg_q, done_q;
	logic signed [15:0] sin_q, cos_q;

	logic signed [16:0] ang_w, fold_w;
	logic               fneg_w;
	logic signed [19:0] dx_w, dy_w, at_w;

	// Q.16 to Q1.14, round half up, clamp to one
	function automatic logic signed [15:0] to_q14(input logic signed [19:0] v, input logic ng);
		logic signed [19:0] r;
		r = (v + 20'sd2) >>> 2;
		if (r > 20'sd16384) r = 20'sd16384;
		if (r < -20'sd16384) r = -20'sd16384;
		if (ng) r = -r;
		return 16'(r);
	endfunction

	// fold the angle into [-pi/2, pi/2]
	always_comb begin
		ang_w  = 17'(angle);
		fold_w = ang_w;
		fneg_w = 1'b0;
		if (ang_w > ogw_pkg::HalfPiQ13) begin
			fold_w = ang_w - ogw_pkg::PiQ13;
			fneg_w = 1'b1;
		end else if (ang_w < -ogw_pkg::HalfPiQ13) begin
			fold_w = ang_w + ogw_pkg::PiQ13;
			fneg_w = 1'b1;
		end
	end

	// shared shifter for one micro-rotation
	assign dx_w = y_q >>> k_q;
	assign dy_w = x_q >>> k_q;
	assign at_w = $signed({4'b0, ogw_pkg::atan_q16(k_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				x_q    <= ogw_pkg::CordicGain;
				y_q    <= '0;
				z_q    <= 20'(fold_w) <<< 3;
				neg_q  <= fneg_w;
			end else if (busy_q) begin
				if (!z_q[19]) begin
					x_q <= x_q - dx_w;
					y_q <= y_q + dy_w;
					z_q <= z_q - at_w;
				end else begin
					x_q <= x_q + dx_w;
					y_q <= y_q - dy_w;
					z_q <= z_q + at_w;
				end
				k_q <= k_q + 4'd1;
				if (k_q == 4'(ogw_pkg::CordicSteps - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				cos_q  <= to_q14(x_q, neg_q);
				sin_q  <= to_q14(y_q, neg_q);
			end
		end
	end

	assign res.done  = done_q;
	assign res.sin_v = sin_q;
	assign res.cos_v = cos_q;

endmodule
